[hdl/salc_pkg.sv]
`default_nettype none

package salc_pkg;

    // access kinds; the remaining code is ignored by the block
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;

    localparam int          CNT_W   = 32;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // outcome of one lookup
    typedef struct packed {
        logic hit;
        logic evicted;
    } salc_status_t;

endpackage

`default_nettype wire

[hdl/salc_ram.sv]
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold the last read word until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/salc_access.sv]
`default_nettype none

module salc_access #(
    parameter int MAX_WAYS = 8,
    parameter int TAG_W    = 64,
    localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int FILL_W  = $clog2(MAX_WAYS + 1)
) (
    input  wire logic [FILL_W-1:0]                  ways,
    input  wire logic [TAG_W-1:0]                   tag,
    input  wire logic [FILL_W-1:0]                  fill,
    input  wire logic [MAX_WAYS-1:0]                valid,
    input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]    rank,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]     tags,
    output salc_pkg::salc_status_t                  status,
    output logic      [FILL_W-1:0]                  fill_new,
    output logic      [MAX_WAYS-1:0]                valid_new,
    output logic      [MAX_WAYS-1:0][RANK_W-1:0]    rank_new,
    output logic      [MAX_WAYS-1:0][TAG_W-1:0]     tags_new
);

    import salc_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic                fill_ok;
    logic [RANK_W-1:0]   hit_way;
    logic [RANK_W-1:0]   victim;
    logic [RANK_W-1:0]   target;
    logic [RANK_W-1:0]   limit;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = FILL_W'(i) < ways;
            match[i]  = in_use[i] && valid[i] && (tags[i] == tag);
        end
    end

    assign hit     = |match;
    assign fill_ok = fill < ways;

    // lowest matching way
    always_comb
    begin
        logic found;
        found   = 1'b0;
        hit_way = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (match[i] && !found)
            begin
                hit_way = RANK_W'(i);
                found   = 1'b1;
            end
        end
    end

    // oldest in-use way, lowest way on a tie
    always_comb
    begin
        logic [RANK_W-1:0] best;
        best   = '0;
        victim = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && valid[i] && (rank[i] > best))
            begin
                best   = rank[i];
                victim = RANK_W'(i);
            end
        end
    end

    always_comb
    begin
        if (hit)
        begin
            target = hit_way;
        end
        else if (fill_ok)
        begin
            target = fill[RANK_W-1:0];
        end
        else
        begin
            target = victim;
        end
    end

    assign limit = rank[hit_way];

    // age every younger line by one, then make the target the newest
    always_comb
    begin
        rank_new = rank;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if ((RANK_W'(i) != target) && in_use[i] && valid[i]
                && (!hit || (rank[i] < limit)) && (rank[i] != RANK_MAX))
            begin
                rank_new[i] = rank[i] + 1'b1;
            end
        end
        rank_new[target] = '0;
    end

    always_comb
    begin
        valid_new = valid;
        tags_new  = tags;
        if (!hit)
        begin
            valid_new[target] = 1'b1;
            tags_new[target]  = tag;
        end
    end

    assign fill_new       = (!hit && fill_ok) ? fill + 1'b1 : fill;
    assign status.hit     = hit;
    assign status.evicted = !hit && !fill_ok;

endmodule

`default_nettype wire

[hdl/set_assoc_lru_cache_sim_top.sv]
`default_nettype none

// Tag-only set-associative cache with LRU replacement and hit, miss and
// eviction counters.
// Request channel: kind and address, taken when in_valid is high and
// in_stall is low. A load or store request makes one lookup and one result;
// a modify request makes two lookups of the same address and two results,
// the second flagged by last. Kind code 3 is taken and dropped.
// Result channel: hit, evicted, last and the three running totals, handed
// over when out_valid is high and out_stall is low.
// The taken request is registered into the lookup state; its first result is
// then registered in the output register, and out_valid rises with it.
// A new request is taken as the last lookup of the one before finishes;
// each lookup is one read-modify-write of a whole set row in the set memory.
// A request taken in the same cycle that writes its set back picks the row
// up from the forwarding register instead of the memory.
// Stall: while a result waits in the output register the lookup holds, and
// so does the request side outside idle; no result is dropped.
// Reset: clears the per-set row valid flags, so every set reads as empty (no
// valid lines, all ranks zero, fill zero) without a clearing pass, and clears
// the counters; configuration returns to 4 set bits, 4 block bits, one way.
// The user writes configuration over the APB port only while idle; not enforced.
module set_assoc_lru_cache_sim_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [salc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [salc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    // requests
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      kind,
    input  wire logic [63:0]                     address,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output logic                                 evicted,
    output logic                                 last,
    output logic      [salc_pkg::CNT_W-1:0]      hit_count,
    output logic      [salc_pkg::CNT_W-1:0]      miss_count,
    output logic      [salc_pkg::CNT_W-1:0]      evict_count
);

    import salc_pkg::*;

    localparam int NUM_SETS = 2 ** MAX_SET_BITS;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int TAG_W    = ADDR_BITS;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);

    // one memory row holds a whole set
    typedef struct packed {
        logic [FILL_W-1:0]               fill;
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tags;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    // configuration registers
    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;

    // control
    state_t              state_reg, state_next;
    logic                second_reg;
    logic                is_modify_reg;
    logic                use_fwd_reg;
    logic                row_ok_reg;
    logic                out_valid_reg;
    logic [NUM_SETS-1:0] row_valid_reg;
    logic [CNT_W-1:0]    hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;

    // payload
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    row_t             fwd_row_reg;
    logic             hit_reg, evicted_reg, last_reg;

    logic [ADDR_BITS-1:0] addr_cut;
    logic [7:0]           sb_eff;
    logic [7:0]           tag_shift;
    logic [ADDR_BITS-1:0] set_shifted;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_in;
    logic [TAG_W-1:0]     tag_in;
    logic [FILL_W-1:0]    ways_eff;

    logic             step;
    logic             finishing;
    logic             accept;
    logic             start;
    logic             known_kind;
    logic [ROW_W-1:0] ram_rdata;
    row_t             row_cur;
    row_t             row_new;
    salc_status_t     st;

    // ---------------- configuration port ----------------
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_SET_BITS:   set_bits_reg   <= pwdata[2:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[5:0];
                REG_WAYS:       ways_reg       <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = {29'd0, set_bits_reg};
            REG_BLOCK_BITS: prdata = {26'd0, block_bits_reg};
            REG_WAYS:       prdata = {28'd0, ways_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- geometry ----------------
    // clamp the set bits and the way count to what the storage holds
    assign sb_eff = (int'(set_bits_reg) > MAX_SET_BITS) ? 8'(MAX_SET_BITS)
                                                         : 8'(set_bits_reg);

    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            ways_eff = FILL_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = FILL_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = FILL_W'(ways_reg);
        end
    end

    // shifts past the address width give zero
    assign addr_cut    = address[ADDR_BITS-1:0];
    assign tag_shift   = {2'b00, block_bits_reg} + sb_eff;
    assign set_shifted = addr_cut >> block_bits_reg;
    assign set_mask    = ~({SET_W{1'b1}} << sb_eff);
    assign set_in      = set_shifted[SET_W-1:0] & set_mask;
    assign tag_in      = addr_cut >> tag_shift;

    // ---------------- handshake and sequencing ----------------
    assign known_kind = (kind == KIND_LOAD) || (kind == KIND_STORE)
                        || (kind == KIND_MODIFY);
    assign step       = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);
    assign finishing  = step && (!is_modify_reg || second_reg);
    assign in_stall   = !((state_reg == ST_IDLE) || finishing);
    assign accept     = in_valid && !in_stall;
    assign start      = accept && known_kind;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (finishing)
                begin
                    state_next = start ? ST_LOOK : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- set memory ----------------
    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (step),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (start),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    // forwarded row wins; a set never written reads as empty
    always_comb
    begin
        if (use_fwd_reg)
        begin
            row_cur = fwd_row_reg;
        end
        else if (row_ok_reg)
        begin
            row_cur = row_t'(ram_rdata);
        end
        else
        begin
            row_cur = '0;
        end
    end

    salc_access #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W)
    ) u_access (
        .ways      (ways_eff),
        .tag       (tag_reg),
        .fill      (row_cur.fill),
        .valid     (row_cur.valid),
        .rank      (row_cur.rank),
        .tags      (row_cur.tags),
        .status    (st),
        .fill_new  (row_new.fill),
        .valid_new (row_new.valid),
        .rank_new  (row_new.rank),
        .tags_new  (row_new.tags)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            second_reg    <= 1'b0;
            is_modify_reg <= 1'b0;
            use_fwd_reg   <= 1'b0;
            row_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // second lookup of a modify reuses the row just written
            if (step && !finishing)
            begin
                second_reg  <= 1'b1;
                use_fwd_reg <= 1'b1;
            end
            else if (start)
            begin
                second_reg  <= 1'b0;
                use_fwd_reg <= step && (set_in == set_reg);
            end
            else if (finishing)
            begin
                second_reg <= 1'b0;
            end

            if (start)
            begin
                is_modify_reg <= (kind == KIND_MODIFY);
                row_ok_reg    <= row_valid_reg[set_in];
            end

            if (step)
            begin
                row_valid_reg[set_reg] <= 1'b1;
                out_valid_reg          <= 1'b1;
                if (st.hit)
                begin
                    if (hit_cnt_reg != CNT_MAX)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (miss_cnt_reg != CNT_MAX)
                    begin
                        miss_cnt_reg <= miss_cnt_reg + 1'b1;
                    end
                    if (st.evicted && (evict_cnt_reg != CNT_MAX))
                    begin
                        evict_cnt_reg <= evict_cnt_reg + 1'b1;
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (step)
        begin
            fwd_row_reg <= row_new;
            hit_reg     <= st.hit;
            evicted_reg <= st.evicted;
            last_reg    <= finishing;
        end
    end

    // counters move only together with a new result, so they show directly
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign evicted     = evicted_reg;
    assign last        = last_reg;
    assign hit_count   = hit_cnt_reg;
    assign miss_count  = miss_cnt_reg;
    assign evict_count = evict_cnt_reg;

    // ---------------- assertions ----------------
    a_modify_second: assert property (@(posedge clk) disable iff (!rst_n)
        step && !finishing |=> (state_reg == ST_LOOK) && second_reg && use_fwd_reg)
        else $error("modify did not advance to its forwarded second lookup");

    a_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
        step && second_reg |-> st.hit)
        else $error("second lookup of a modify missed");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && st.evicted |-> row_cur.fill >= ways_eff)
        else $error("eviction from a set that still has an empty way");

    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finishing |=> !second_reg)
        else $error("second lookup flag left set after the last result");

endmodule

`default_nettype wire
